// ===== design/mtn_pkg.sv =====
// Package for the markup text normaliser: character constants, the command
// that travels from the classifying front end to the output sequencer, and helpers.
// No dependencies.
package mtn_pkg;

	localparam int NAME_MAX = 4;
	localparam int LEN_W    = $clog2(NAME_MAX + 1);
	localparam int IDX_W    = $clog2(NAME_MAX);
	// Longest command: '&', the name, and two tail bytes.
	localparam int POS_W    = $clog2(NAME_MAX + 4);
	localparam int Q_DEPTH  = 2;
	localparam int QP_W     = $clog2(Q_DEPTH);
	localparam int QC_W     = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_P    = 8'h70;
	localparam logic [7:0] CH_L    = 8'h6C;
	localparam logic [7:0] CH_G    = 8'h67;
	localparam logic [7:0] CH_T    = 8'h74;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_mark;
	} tail_t;

	// One command: an optional raw flush of '&' and the held name, then up to
	// two tail bytes.
	typedef struct packed {
		logic                      flush;
		logic [LEN_W-1:0]          len;
		logic [NAME_MAX-1:0][7:0]  name;
		logic [1:0]                ntail;
		tail_t [1:0]               tail;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

	// Replacement for the held name, or NUL when it names nothing.
	function automatic logic [7:0] lookup_ref(input logic [NAME_MAX-1:0][7:0] nm,
	                                          input logic [LEN_W-1:0] n);
		logic [7:0] r;
		r = CH_NUL;
		if (n == LEN_W'(3) && fold(nm[0]) == CH_A && fold(nm[1]) == CH_M &&
		    fold(nm[2]) == CH_P) begin
			r = CH_AMP;
		end else if (n == LEN_W'(2) && fold(nm[1]) == CH_T) begin
			if (fold(nm[0]) == CH_L) begin
				r = CH_LT;
			end else if (fold(nm[0]) == CH_G) begin
				r = CH_GT;
			end
		end
		return r;
	endfunction

endpackage

// ===== design/mtn_in_if.sv =====
// Input channel of the markup text normaliser: one text byte or an end of stream.
// Standalone; no package needed.
interface mtn_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_stream;

	modport source (output valid, output in_byte, output end_of_stream, input ready);
	modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// ===== design/mtn_out_if.sv =====
// Result channel of the markup text normaliser: one output byte or end marker.
// Standalone; no package needed.
interface mtn_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       text_end;
	logic       last;

	modport source (output valid, output out_byte, output text_end, output last,
	                input ready);
	modport sink   (input valid, input out_byte, input text_end, input last,
	                output ready);
endinterface

// ===== design/mtn_cfg_if.sv =====
// Configuration write channel of the markup text normaliser.
// Standalone; no package needed.
interface mtn_cfg_if;
	logic valid;
	logic ready;
	logic collapse_whitespace;

	modport source (output valid, output collapse_whitespace, input ready);
	modport sink   (input valid, input collapse_whitespace, output ready);
endinterface

// ===== design/mtn_front.sv =====
// Front end: takes input bytes, tracks whitespace and reference state, and
// turns each byte into at most one command. Depends on mtn_pkg and the interfaces.
module mtn_front (
	input  logic             clk,
	input  logic             arst_n,
	mtn_in_if.sink           in_ch,
	mtn_cfg_if.sink          cfg_ch,
	input  mtn_pkg::q_stat_t q_stat,
	output logic             push,
	output mtn_pkg::cmd_t    push_cmd
);
	import mtn_pkg::*;

	logic                     collapse_q;
	logic                     pws_q, pws_d;
	logic                     in_ref_q, in_ref_d;
	logic [LEN_W-1:0]         len_q, len_d;
	logic [NAME_MAX-1:0][7:0] name_q;
	logic                     store_en;
	logic                     need_push;
	logic                     accept;
	logic                     sp;
	logic                     first;
	logic [7:0]               rep;
	logic [7:0]               plain;
	cmd_t                     cmd;

	assign in_ch.ready  = !q_stat.full;
	assign cfg_ch.ready = 1'b1;
	assign accept       = in_ch.valid && in_ch.ready;
	assign sp           = is_space(in_ch.in_byte);
	assign rep          = lookup_ref(name_q, len_q);
	assign plain        = collapse_q ? CH_SP : in_ch.in_byte;

	always_comb begin
		cmd       = '0;
		cmd.len   = len_q;
		cmd.name  = name_q;
		need_push = 1'b0;
		store_en  = 1'b0;
		first     = 1'b0;
		pws_d     = pws_q;
		in_ref_d  = in_ref_q;
		len_d     = len_q;
		if (in_ch.end_of_stream || in_ch.in_byte == CH_LT) begin
			cmd.flush   = in_ref_q;
			cmd.tail[0] = '{ch: CH_NUL, end_mark: 1'b1};
			cmd.ntail   = 2'd1;
			need_push   = 1'b1;
			in_ref_d    = 1'b0;
			len_d       = '0;
			pws_d       = 1'b0;
		end else if (!in_ref_q) begin
			if (in_ch.in_byte == CH_AMP) begin
				in_ref_d = 1'b1;
				len_d    = '0;
				pws_d    = 1'b0;
			end else if (sp && collapse_q) begin
				if (!pws_q) begin
					cmd.tail[0] = '{ch: CH_SP, end_mark: 1'b0};
					cmd.ntail   = 2'd1;
					need_push   = 1'b1;
				end
				pws_d = 1'b1;
			end else begin
				cmd.tail[0] = '{ch: in_ch.in_byte, end_mark: 1'b0};
				cmd.ntail   = 2'd1;
				need_push   = 1'b1;
				pws_d       = 1'b0;
			end
		end else if (in_ch.in_byte == CH_SEMI || sp) begin
			// Ends a reference: replacement or flush, then terminator; a replacement eats ';'.
			cmd.flush = (rep == CH_NUL);
			need_push = 1'b1;
			in_ref_d  = 1'b0;
			len_d     = '0;
			pws_d     = 1'b0;
			if (rep != CH_NUL) begin
				cmd.tail[0] = '{ch: rep, end_mark: 1'b0};
				first       = 1'b1;
			end else if (in_ch.in_byte == CH_SEMI) begin
				cmd.tail[0] = '{ch: CH_SEMI, end_mark: 1'b0};
				first       = 1'b1;
			end
			if (sp) begin
				if (first) begin
					cmd.tail[1] = '{ch: plain, end_mark: 1'b0};
				end else begin
					cmd.tail[0] = '{ch: plain, end_mark: 1'b0};
				end
				pws_d = collapse_q;
			end
			cmd.ntail = {1'b0, first} + {1'b0, sp};
		end else if (in_ch.in_byte == CH_AMP) begin
			cmd.flush = 1'b1;
			need_push = 1'b1;
			len_d     = '0;
			pws_d     = 1'b0;
		end else if (len_q < LEN_W'(NAME_MAX)) begin
			store_en = 1'b1;
			len_d    = len_q + LEN_W'(1);
		end else begin
			cmd.flush   = 1'b1;
			cmd.tail[0] = '{ch: in_ch.in_byte, end_mark: 1'b0};
			cmd.ntail   = 2'd1;
			need_push   = 1'b1;
			in_ref_d    = 1'b0;
			len_d       = '0;
			pws_d       = 1'b0;
		end
	end

	assign push     = accept && need_push;
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collapse_q <= 1'b1;
			pws_q      <= 1'b0;
			in_ref_q   <= 1'b0;
			len_q      <= '0;
		end else begin
			if (cfg_ch.valid) begin
				collapse_q <= cfg_ch.collapse_whitespace;
			end
			if (accept) begin
				pws_q    <= pws_d;
				in_ref_q <= in_ref_d;
				len_q    <= len_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && store_en) begin
			name_q[len_q[IDX_W-1:0]] <= in_ch.in_byte;
		end
	end

endmodule

// ===== design/mtn_cmd_fifo.sv =====
// Short command queue between the front end and the output sequencer.
// Depends on mtn_pkg.
module mtn_cmd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mtn_pkg::cmd_t    push_cmd,
	input  logic             pop,
	output mtn_pkg::cmd_t    pop_cmd,
	output mtn_pkg::q_stat_t q_stat
);
	import mtn_pkg::*;

	cmd_t            entry_q [Q_DEPTH];
	logic [QP_W-1:0] wr_q;
	logic [QP_W-1:0] rd_q;
	logic [QC_W-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == QC_W'(Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_cmd      = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QP_W'(Q_DEPTH - 1)) ? '0 : wr_q + QP_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QP_W'(Q_DEPTH - 1)) ? '0 : rd_q + QP_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QC_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

endmodule

// ===== design/mtn_back.sv =====
// Output sequencer: holds one command and gives out its results one per cycle
// while out_ch is ready. Depends on mtn_pkg and mtn_out_if.
module mtn_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mtn_pkg::q_stat_t q_stat,
	input  mtn_pkg::cmd_t    pop_cmd,
	output logic             pop,
	mtn_out_if.source        out_ch
);
	import mtn_pkg::*;

	logic             busy_q;
	cmd_t             cmd_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] nflush;
	logic [POS_W-1:0] total;
	logic [POS_W-1:0] rel;
	logic [POS_W-1:0] name_pos;
	logic             is_last;
	logic             fire;

	assign nflush   = cmd_q.flush ? POS_W'(cmd_q.len) + POS_W'(1) : '0;
	assign total    = nflush + POS_W'(cmd_q.ntail);
	assign is_last  = (pos_q == total - POS_W'(1));
	assign rel      = pos_q - nflush;
	assign name_pos = pos_q - POS_W'(1);
	assign fire     = out_ch.valid && out_ch.ready;
	assign pop      = !q_stat.empty && (!busy_q || (fire && is_last));

	always_comb begin
		out_ch.valid    = busy_q;
		out_ch.last     = is_last;
		out_ch.text_end = 1'b0;
		if (pos_q < nflush) begin
			out_ch.out_byte = (pos_q == '0) ? CH_AMP : cmd_q.name[name_pos[IDX_W-1:0]];
		end else begin
			out_ch.out_byte = cmd_q.tail[rel[0]].ch;
			out_ch.text_end = cmd_q.tail[rel[0]].end_mark;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (fire && is_last) begin
				busy_q <= 1'b0;
			end else if (fire) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= pop_cmd;
		end
	end

endmodule

// ===== design/markup_text_normalizer_core.sv =====
// Markup text normaliser: collapses whitespace runs and decodes &amp; &lt; &gt;.
// in_ch takes one text byte (or an end of stream) per transaction; out_ch gives
// the resulting bytes, an end marker (text_end) after '<' or end of stream, and
// last on the final result that an input byte causes. Some bytes cause none.
// cfg_ch writes collapse_whitespace; it is always ready and resets to 1.
// The front end classifies each byte in the cycle it is accepted and queues at
// most one command in a two-entry queue; the back end turns a command into its
// results at one per cycle while out_ch is ready. The first result of a byte is
// offered after its command passes the queue entry and the back end's cmd_q.
// Throughput: one byte per cycle when each byte gives one result and out_ch is
// ready; a byte that flushes a held reference gives 1 to NAME_MAX + 2 results,
// sent one by one, and the front end stalls once the queue is full.
// When the receiver stalls, the current result holds and the queue fills, after
// which in_ch.ready falls. Reset clears the reference and whitespace state and
// empties the queue; the held name bytes are not cleared.
// Depends on mtn_pkg, the three channel interfaces and the submodules.
module markup_text_normalizer_core (
	input  logic       clk,
	input  logic       arst_n,
	mtn_in_if.sink     in_ch,
	mtn_cfg_if.sink    cfg_ch,
	mtn_out_if.source  out_ch
);
	import mtn_pkg::*;

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	cmd_t    push_cmd;
	cmd_t    pop_cmd;

	mtn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg_ch   (cfg_ch),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mtn_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_stat   (q_stat)
	);

	mtn_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.pop_cmd (pop_cmd),
		.pop     (pop),
		.out_ch  (out_ch)
	);

`ifndef SYNTH
	// An end marker is always the final result of its input and carries no byte.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.text_end |-> out_ch.last && out_ch.out_byte == CH_NUL)
		else $error("end marker not last or carries a byte");

	// A queued command means the sequencer presents a result from the next cycle.
	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty |=> out_ch.valid)
		else $error("queue holds a command while the output is idle");

	// The queue never takes a command while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full && !pop |=> !$rose(q_stat.empty) && $past(!push))
		else $error("command pushed into a full queue");
`endif

endmodule
